// ===== rtl/srb_pkg.sv =====
// Package for the six-register bound-pointer machine.
// Holds the opcodes, configuration indexes, payload structs and shared types.
// No dependencies.
`timescale 1ns / 1ps

package srb_pkg;

	// register file geometry
	localparam int NUM_REGS = 6;
	localparam int REG_W    = 64;
	localparam int IDX_W    = 3;
	localparam int OPND_W   = 32;
	localparam int LEN_W    = 16;
	localparam int KIND_W   = 4;

	// index of the highest register, also used when the pointer choice is out of range
	localparam logic [IDX_W-1:0] LAST_REG = IDX_W'(NUM_REGS - 1);

	// opcodes
	localparam logic [KIND_W-1:0] OP_ADDR = 4'd0;
	localparam logic [KIND_W-1:0] OP_ADDI = 4'd1;
	localparam logic [KIND_W-1:0] OP_MULR = 4'd2;
	localparam logic [KIND_W-1:0] OP_MULI = 4'd3;
	localparam logic [KIND_W-1:0] OP_BANR = 4'd4;
	localparam logic [KIND_W-1:0] OP_BANI = 4'd5;
	localparam logic [KIND_W-1:0] OP_BORR = 4'd6;
	localparam logic [KIND_W-1:0] OP_BORI = 4'd7;
	localparam logic [KIND_W-1:0] OP_SETR = 4'd8;
	localparam logic [KIND_W-1:0] OP_SETI = 4'd9;
	localparam logic [KIND_W-1:0] OP_GTIR = 4'd10;
	localparam logic [KIND_W-1:0] OP_GTRI = 4'd11;
	localparam logic [KIND_W-1:0] OP_GTRR = 4'd12;
	localparam logic [KIND_W-1:0] OP_EQIR = 4'd13;
	localparam logic [KIND_W-1:0] OP_EQRI = 4'd14;
	localparam logic [KIND_W-1:0] OP_EQRR = 4'd15;

	// configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_POINTER_REGISTER = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PROGRAM_LENGTH   = 1'd1;
	localparam int CFG_DATA_W = LEN_W;

	// configuration reset values
	localparam logic [IDX_W-1:0] POINTER_REGISTER_RST = 3'd1;
	localparam logic [LEN_W-1:0] PROGRAM_LENGTH_RST   = '0;

	typedef logic [REG_W-1:0] reg_word_t;
	typedef logic [NUM_REGS-1:0][REG_W-1:0] reg_file_t;

	// one instruction
	typedef struct packed {
		logic        [KIND_W-1:0] kind;
		logic signed [OPND_W-1:0] operand_a;
		logic signed [OPND_W-1:0] operand_b;
		logic        [IDX_W-1:0]  dest_index;
	} in_item_t;

	// one result
	typedef struct packed {
		logic signed [REG_W-1:0] next_pointer;
		logic signed [REG_W-1:0] first_register;
		logic                    halted;
	} out_item_t;

	// write-back control from the top level to the register file
	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] dest;
		logic [IDX_W-1:0] ptr;
	} wb_ctrl_t;

endpackage

// ===== rtl/srb_alu.sv =====
// Execute unit: operand fetch from the register file and the sixteen operations.
// Depends on srb_pkg.
`timescale 1ns / 1ps

module srb_alu (
	input  srb_pkg::reg_file_t regs,
	input  srb_pkg::in_item_t  item,
	output srb_pkg::reg_word_t result
);

	localparam int HALF_W = srb_pkg::REG_W / 2;

	srb_pkg::reg_word_t va;
	srb_pkg::reg_word_t vb;
	srb_pkg::reg_word_t ia;
	srb_pkg::reg_word_t ib;
	srb_pkg::reg_word_t mul_b;
	srb_pkg::reg_word_t prod_ll;
	logic [HALF_W-1:0]  prod_cross;
	srb_pkg::reg_word_t product;
	srb_pkg::reg_word_t add_b;
	logic               gt_ir;
	logic               gt_ri;
	logic               gt_rr;

	// register reads: an index outside the file reads as zero
	function automatic srb_pkg::reg_word_t read_reg(input srb_pkg::reg_file_t rf,
			input logic [srb_pkg::OPND_W-1:0] idx);
		srb_pkg::reg_word_t v;
		v = '0;
		for (int i = 0; i < srb_pkg::NUM_REGS; i++) begin
			if (idx == srb_pkg::OPND_W'(i))
				v = rf[i];
		end
		return v;
	endfunction

	assign va = read_reg(regs, item.operand_a);
	assign vb = read_reg(regs, item.operand_b);

	// immediates, sign extended
	assign ia = srb_pkg::REG_W'(item.operand_a);
	assign ib = srb_pkg::REG_W'(item.operand_b);

	// low 64 bits of the product from three 32x32 partial products
	assign mul_b      = (item.kind == srb_pkg::OP_MULI) ? ib : vb;
	assign prod_ll    = {{HALF_W{1'b0}}, va[HALF_W-1:0]} * {{HALF_W{1'b0}}, mul_b[HALF_W-1:0]};
	assign prod_cross = HALF_W'(va[HALF_W-1:0] * mul_b[srb_pkg::REG_W-1:HALF_W])
	                  + HALF_W'(va[srb_pkg::REG_W-1:HALF_W] * mul_b[HALF_W-1:0]);
	assign product    = prod_ll + {prod_cross, {HALF_W{1'b0}}};

	assign add_b = (item.kind == srb_pkg::OP_ADDI) ? ib : vb;

	// signed compares
	assign gt_ir = $signed(ia) > $signed(vb);
	assign gt_ri = $signed(va) > $signed(ib);
	assign gt_rr = $signed(va) > $signed(vb);

	// operation select
	always_comb begin
		unique case (item.kind)
			srb_pkg::OP_ADDR, srb_pkg::OP_ADDI: result = va + add_b;
			srb_pkg::OP_MULR, srb_pkg::OP_MULI: result = product;
			srb_pkg::OP_BANR: result = va & vb;
			srb_pkg::OP_BANI: result = va & ib;
			srb_pkg::OP_BORR: result = va | vb;
			srb_pkg::OP_BORI: result = va | ib;
			srb_pkg::OP_SETR: result = va;
			srb_pkg::OP_SETI: result = ia;
			srb_pkg::OP_GTIR: result = srb_pkg::REG_W'(gt_ir);
			srb_pkg::OP_GTRI: result = srb_pkg::REG_W'(gt_ri);
			srb_pkg::OP_GTRR: result = srb_pkg::REG_W'(gt_rr);
			srb_pkg::OP_EQIR: result = srb_pkg::REG_W'(ia == vb);
			srb_pkg::OP_EQRI: result = srb_pkg::REG_W'(va == ib);
			srb_pkg::OP_EQRR: result = srb_pkg::REG_W'(va == vb);
			default:          result = '0;
		endcase
	end

endmodule

// ===== rtl/srb_regfile.sv =====
// Six-entry register file with write-back and pointer increment in one update.
// Depends on srb_pkg.
`timescale 1ns / 1ps

module srb_regfile (
	input  logic               clk,
	input  logic               arst_n,
	input  srb_pkg::wb_ctrl_t  wb,
	input  srb_pkg::reg_word_t result,
	output srb_pkg::reg_file_t regs,
	output srb_pkg::reg_word_t next_pointer,
	output srb_pkg::reg_word_t next_first
);

	srb_pkg::reg_file_t regs_q;
	srb_pkg::reg_file_t regs_nxt;

	// destination write first (indexes 6 and 7 drop it), then bump the pointer
	always_comb begin
		for (int i = 0; i < srb_pkg::NUM_REGS; i++) begin
			regs_nxt[i] = (wb.dest == srb_pkg::IDX_W'(i)) ? result : regs_q[i];
			if (wb.ptr == srb_pkg::IDX_W'(i))
				regs_nxt[i] = regs_nxt[i] + srb_pkg::REG_W'(1);
		end
	end

	// pointer value after the increment
	always_comb begin
		next_pointer = '0;
		for (int i = 0; i < srb_pkg::NUM_REGS; i++) begin
			if (wb.ptr == srb_pkg::IDX_W'(i))
				next_pointer = regs_nxt[i];
		end
	end

	assign next_first = regs_nxt[0];
	assign regs       = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (wb.en) begin
			regs_q <= regs_nxt;
		end
	end

endmodule

// ===== rtl/six_register_ip_bound_machine.sv =====
// Top level of the six-register bound-pointer machine: handshakes, config, result register.
// Depends on srb_pkg, srb_alu and srb_regfile.
//
//   channel  direction  signals                          moves
//   in       sink       in_valid, in_stall, in_data      one instruction
//   out      source     out_valid, out_stall, out_data   one result
//   cfg      sink       cfg_write_en, cfg_index, cfg_data one register write
//
// One instruction per cycle sustained while the result is not stalled. A transaction
// is captured in the input register and executed through the ALU and register file
// once the result register is free or being emptied; the register file and the result
// register load at the same edge, and the result is then offered until it is taken.
// The 64-bit multiply (three 32x32 partial products) sets the critical path.
// Reset clears the registers and sets the pointer choice to 1 and the program length to 0.
// A stalled result holds the input register; in_stall rises only then.
`timescale 1ns / 1ps

module six_register_ip_bound_machine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  srb_pkg::in_item_t                   in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output srb_pkg::out_item_t                  out_data,
	input  logic                                cfg_write_en,
	input  logic [srb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [srb_pkg::CFG_DATA_W-1:0]      cfg_data
);

	logic                           valid_s1;
	srb_pkg::in_item_t              item_s1;
	logic                           out_valid_q;
	srb_pkg::out_item_t             out_data_q;
	logic [srb_pkg::IDX_W-1:0]      pointer_register_q;
	logic [srb_pkg::LEN_W-1:0]      program_length_q;

	logic                           advance;
	logic                           accept;
	logic [srb_pkg::IDX_W-1:0]      ptr_idx;
	srb_pkg::wb_ctrl_t              wb;
	srb_pkg::reg_file_t             regs;
	srb_pkg::reg_word_t             result;
	srb_pkg::reg_word_t             next_pointer;
	srb_pkg::reg_word_t             next_first;
	logic                           halt;

	// handshake: execute when the result register is free or being emptied
	assign advance  = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pointer_register_q <= srb_pkg::POINTER_REGISTER_RST;
			program_length_q   <= srb_pkg::PROGRAM_LENGTH_RST;
		end else if (cfg_write_en) begin
			unique case (cfg_index)
				srb_pkg::CFG_POINTER_REGISTER: pointer_register_q <= cfg_data[srb_pkg::IDX_W-1:0];
				srb_pkg::CFG_PROGRAM_LENGTH:   program_length_q   <= cfg_data[srb_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// pointer choice of 6 or 7 behaves as the last register
	assign ptr_idx = (pointer_register_q > srb_pkg::LAST_REG) ? srb_pkg::LAST_REG
	                                                          : pointer_register_q;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= in_data;
	end

	// execute
	srb_alu u_alu (
		.regs   (regs),
		.item   (item_s1),
		.result (result)
	);

	assign wb.en   = advance;
	assign wb.dest = item_s1.dest_index;
	assign wb.ptr  = ptr_idx;

	srb_regfile u_regfile (
		.clk          (clk),
		.arst_n       (arst_n),
		.wb           (wb),
		.result       (result),
		.regs         (regs),
		.next_pointer (next_pointer),
		.next_first   (next_first)
	);

	// halt when the new pointer is negative or past the program
	assign halt = next_pointer[srb_pkg::REG_W-1]
	           || (next_pointer >= srb_pkg::REG_W'(program_length_q));

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q.next_pointer   <= next_pointer;
			out_data_q.first_register <= next_first;
			out_data_q.halted         <= halt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for six_register_ip_bound_machine.
// Holds a shadow of the register machine in a small class and drives the block through plain tasks.
// Depends on srb_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_ITEMS = 135;
	localparam int HOLD_CYCLES = 400;

	// shadow of the register file and settings; queue of steps still to be seen
	class register_machine_shadow;
		srb_pkg::out_item_t                awaited_steps[$];
		srb_pkg::reg_word_t                regs[srb_pkg::NUM_REGS];
		logic [srb_pkg::IDX_W-1:0]         ptr_choice;
		logic [srb_pkg::LEN_W-1:0]         prog_len;
		int                                mismatches;
		int                                steps_seen;

		function new();
			foreach (regs[i]) regs[i] = '0;
			ptr_choice = srb_pkg::POINTER_REGISTER_RST;
			prog_len   = srb_pkg::PROGRAM_LENGTH_RST;
			mismatches = 0;
			steps_seen = 0;
		endfunction

		function void write_setting(logic [srb_pkg::CFG_IDX_W-1:0] idx,
				logic [srb_pkg::CFG_DATA_W-1:0] val);
			case (idx)
			srb_pkg::CFG_POINTER_REGISTER: begin
				ptr_choice = val[srb_pkg::IDX_W-1:0];
			end
			srb_pkg::CFG_PROGRAM_LENGTH: begin
				prog_len = val[srb_pkg::LEN_W-1:0];
			end
			default: begin
			end
			endcase
		endfunction

		// run one accepted instruction and queue the step it must produce
		function void execute(srb_pkg::in_item_t ins);
			logic [srb_pkg::OPND_W-1:0] ra, rb;
			srb_pkg::reg_word_t         va, vb, ia, ib, res;
			logic [srb_pkg::IDX_W-1:0]  p;
			srb_pkg::out_item_t         step;
			ra = ins.operand_a;
			rb = ins.operand_b;
			va = '0;
			vb = '0;
			// register operands outside the file read as zero
			if (ra < srb_pkg::NUM_REGS) va = regs[ra[srb_pkg::IDX_W-1:0]];
			if (rb < srb_pkg::NUM_REGS) vb = regs[rb[srb_pkg::IDX_W-1:0]];
			ia = {{(srb_pkg::REG_W-srb_pkg::OPND_W){ins.operand_a[srb_pkg::OPND_W-1]}},
				ins.operand_a};
			ib = {{(srb_pkg::REG_W-srb_pkg::OPND_W){ins.operand_b[srb_pkg::OPND_W-1]}},
				ins.operand_b};
			case (ins.kind)
			srb_pkg::OP_ADDR: res = va + vb;
			srb_pkg::OP_ADDI: res = va + ib;
			srb_pkg::OP_MULR: res = va * vb;
			srb_pkg::OP_MULI: res = va * ib;
			srb_pkg::OP_BANR: res = va & vb;
			srb_pkg::OP_BANI: res = va & ib;
			srb_pkg::OP_BORR: res = va | vb;
			srb_pkg::OP_BORI: res = va | ib;
			srb_pkg::OP_SETR: res = va;
			srb_pkg::OP_SETI: res = ia;
			srb_pkg::OP_GTIR: res = ($signed(ia) > $signed(vb)) ? 64'd1 : 64'd0;
			srb_pkg::OP_GTRI: res = ($signed(va) > $signed(ib)) ? 64'd1 : 64'd0;
			srb_pkg::OP_GTRR: res = ($signed(va) > $signed(vb)) ? 64'd1 : 64'd0;
			srb_pkg::OP_EQIR: res = (ia == vb) ? 64'd1 : 64'd0;
			srb_pkg::OP_EQRI: res = (va == ib) ? 64'd1 : 64'd0;
			srb_pkg::OP_EQRR: res = (va == vb) ? 64'd1 : 64'd0;
			default: res = '0;
			endcase
			// destinations 6 and 7 drop the write
			if (ins.dest_index < srb_pkg::NUM_REGS) regs[ins.dest_index] = res;
			// pointer choices above the file fall back to the last register
			p = (ptr_choice > srb_pkg::LAST_REG) ? srb_pkg::LAST_REG : ptr_choice;
			regs[p] = regs[p] + 64'd1;
			step.next_pointer   = regs[p];
			step.first_register = regs[0];
			step.halted = regs[p][srb_pkg::REG_W-1] ||
				(regs[p] >= {{(srb_pkg::REG_W-srb_pkg::LEN_W){1'b0}}, prog_len});
			awaited_steps.insert(awaited_steps.size(), step);
		endfunction

		function void compare_step(srb_pkg::out_item_t got);
			srb_pkg::out_item_t want;
			bit                 bad;
			steps_seen++;
			if (awaited_steps.size() == 0) begin
				if (mismatches < 10)
					$display("tb: unexpected step ptr %h reg0 %h halt %b",
						got.next_pointer, got.first_register, got.halted);
				mismatches++;
				return;
			end
			want = awaited_steps.pop_front();
			bad = (got.next_pointer !== want.next_pointer) ||
				(got.first_register !== want.first_register) ||
				(got.halted !== want.halted);
			if (bad) begin
				if (mismatches < 10)
					$display({"tb: step %0d wants ptr %h reg0 %h halt %b,",
						" got ptr %h reg0 %h halt %b"},
						steps_seen, want.next_pointer, want.first_register, want.halted,
						got.next_pointer, got.first_register, got.halted);
				mismatches++;
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	srb_pkg::in_item_t              in_data = '0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	srb_pkg::out_item_t             out_data;
	logic                           cfg_write_en = 1'b0;
	logic [srb_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [srb_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	register_machine_shadow shadow = new();

	int cycle_count = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_left = 0;
	int instr_sent = 0;
	int settings_applied = 0;

	six_register_ip_bound_machine i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_data     (out_data),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// watchdog
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb: failure");
		$finish;
	end

	// receiver back-pressure: a long hold when asked, random stalls otherwise
	initial begin
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// check every result transaction
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			shadow.compare_step(out_data);
	end

	function automatic srb_pkg::in_item_t encode(logic [srb_pkg::KIND_W-1:0] kind,
			int a, int b, int c);
		srb_pkg::in_item_t it;
		it.kind       = kind;
		it.operand_a  = a;
		it.operand_b  = b;
		it.dest_index = srb_pkg::IDX_W'(c);
		return it;
	endfunction

	// mostly register indexes, some out-of-range indexes, extremes and raw words
	function automatic logic [srb_pkg::OPND_W-1:0] random_operand();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel <= 5) return srb_pkg::OPND_W'($urandom_range(srb_pkg::NUM_REGS-1));
		if (sel == 6) return srb_pkg::OPND_W'($urandom_range(7, 6));
		if (sel == 7) return srb_pkg::OPND_W'(-int'($urandom_range(4, 1)));
		if (sel == 8) return $urandom();
		case ($urandom_range(3))
		0: return 32'h7FFF_FFFF;
		1: return 32'h8000_0000;
		2: return 32'hFFFF_FFFF;
		default: return '0;
		endcase
	endfunction

	// random instruction; a fair share steers the pointer so halting flips both ways
	function automatic srb_pkg::in_item_t random_instr();
		srb_pkg::in_item_t         it;
		int unsigned               sel;
		logic [srb_pkg::IDX_W-1:0] p;
		int                        target;
		p = (shadow.ptr_choice > srb_pkg::LAST_REG) ? srb_pkg::LAST_REG : shadow.ptr_choice;
		sel = $urandom_range(99);
		it.kind       = srb_pkg::KIND_W'($urandom_range(15));
		it.operand_a  = random_operand();
		it.operand_b  = random_operand();
		it.dest_index = srb_pkg::IDX_W'($urandom_range(srb_pkg::NUM_REGS-1));
		if (sel < 10) begin
			// noise
			it.operand_a  = $urandom();
			it.operand_b  = $urandom();
			it.dest_index = srb_pkg::IDX_W'($urandom_range(7));
		end else if (sel < 16) begin
			it.dest_index = srb_pkg::IDX_W'($urandom_range(7, 6));
		end else if (sel < 36) begin
			// jumps: near the program end, back to the start, relative, conditional skip
			it.dest_index = p;
			case ($urandom_range(3))
			0: begin
				target = int'(shadow.prog_len) - int'($urandom_range(3));
				it.kind = srb_pkg::OP_SETI;
				it.operand_a = target;
			end
			1: begin
				it.kind = srb_pkg::OP_SETI;
				it.operand_a = $urandom_range(4);
			end
			2: begin
				it.kind = srb_pkg::OP_ADDI;
				it.operand_a = srb_pkg::OPND_W'(p);
				it.operand_b = int'($urandom_range(8)) - 4;
			end
			default: begin
				it.kind = srb_pkg::OP_ADDR;
				it.operand_a = srb_pkg::OPND_W'(p);
				it.operand_b = $urandom_range(srb_pkg::NUM_REGS-1);
			end
			endcase
		end
		return it;
	endfunction

	// offer one instruction transaction, with a random idle gap ahead of it
	task automatic send_instr(srb_pkg::in_item_t it);
		int gap;
		gap = 0;
		while ($urandom_range(99) < send_idle_pct) gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= it;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		shadow.execute(it);
		instr_sent++;
	endtask

	task automatic pause_until_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (shadow.awaited_steps.size() != 0) @(posedge clk);
	endtask

	task automatic apply_settings(logic [srb_pkg::IDX_W-1:0] ptr,
			logic [srb_pkg::LEN_W-1:0] len);
		cfg_write_en <= 1'b1;
		cfg_index    <= srb_pkg::CFG_POINTER_REGISTER;
		cfg_data     <= srb_pkg::CFG_DATA_W'(ptr);
		@(posedge clk);
		cfg_index    <= srb_pkg::CFG_PROGRAM_LENGTH;
		cfg_data     <= srb_pkg::CFG_DATA_W'(len);
		@(posedge clk);
		cfg_write_en <= 1'b0;
		shadow.write_setting(srb_pkg::CFG_POINTER_REGISTER, srb_pkg::CFG_DATA_W'(ptr));
		shadow.write_setting(srb_pkg::CFG_PROGRAM_LENGTH, srb_pkg::CFG_DATA_W'(len));
		settings_applied++;
	endtask

	initial begin
		logic [srb_pkg::IDX_W-1:0] ptr_list[8];
		logic [srb_pkg::LEN_W-1:0] len_list[8];
		int                        idle_send[4];
		int                        idle_recv[4];
		ptr_list  = '{3'd0, 3'd5, 3'd6, 3'd2, 3'd7, 3'd1, 3'd3, 3'd4};
		len_list  = '{16'd40, 16'd65535, 16'd25, 16'd0, 16'd12, 16'd65535, 16'd1, 16'd100};
		idle_send = '{0, 84, 0, 20};
		idle_recv = '{0, 0, 84, 20};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part on reset settings: pointer in register 1, empty program
		send_instr(encode(srb_pkg::OP_SETI, 32'h7FFF_FFFF, 0, 2));
		send_instr(encode(srb_pkg::OP_SETI, 32'h8000_0000, 0, 3));  // sign extension
		send_instr(encode(srb_pkg::OP_MULR, 3, 3, 4));               // 2^62
		send_instr(encode(srb_pkg::OP_ADDR, 4, 4, 4));               // wraps to most negative
		send_instr(encode(srb_pkg::OP_ADDI, 4, -1, 5));              // wraps to most positive
		send_instr(encode(srb_pkg::OP_GTRR, 5, 4, 0));
		send_instr(encode(srb_pkg::OP_GTRI, 4, 0, 0));
		send_instr(encode(srb_pkg::OP_GTIR, -1, 4, 0));
		send_instr(encode(srb_pkg::OP_EQRR, 4, 4, 0));
		send_instr(encode(srb_pkg::OP_EQIR, 32'h8000_0000, 3, 0));
		send_instr(encode(srb_pkg::OP_EQRI, 3, 32'h8000_0000, 0));
		send_instr(encode(srb_pkg::OP_BANR, 5, 2, 0));
		send_instr(encode(srb_pkg::OP_BANI, 5, -16, 0));
		send_instr(encode(srb_pkg::OP_BORR, 2, 3, 0));
		send_instr(encode(srb_pkg::OP_BORI, 0, 32'h1234_5678, 0));
		send_instr(encode(srb_pkg::OP_MULI, 5, -1, 0));
		send_instr(encode(srb_pkg::OP_SETR, 4, 0, 0));
		send_instr(encode(srb_pkg::OP_ADDR, 6, -1, 0));     // out-of-range operands read zero
		send_instr(encode(srb_pkg::OP_MULR, 7, 32'h7FFF_FFFF, 2));
		send_instr(encode(srb_pkg::OP_SETI, 99, 0, 7));              // write dropped
		send_instr(encode(srb_pkg::OP_SETI, 99, 0, 6));
		send_instr(encode(srb_pkg::OP_SETI, -5, 0, 1));              // pointer goes negative
		send_instr(encode(srb_pkg::OP_ADDI, 1, 10, 1));
		send_instr(encode(srb_pkg::OP_SETR, 1, 0, 1));
		send_instr(encode(srb_pkg::OP_EQRR, 0, 0, 5));

		// random phases, each with its own settings and idle pattern
		for (int ph = 0; ph < 8; ph++) begin
			pause_until_drained();
			apply_settings(ptr_list[ph], len_list[ph]);
			send_idle_pct = idle_send[ph % 4];
			stall_pct     = idle_recv[ph % 4];
			// long receiver hold while the sender keeps offering, to fill the pipe
			if (ph == 4) hold_left = HOLD_CYCLES;
			for (int n = 0; n < PHASE_ITEMS; n++) send_instr(random_instr());
		end

		pause_until_drained();
		repeat (20) @(posedge clk);

		$display("tb: %0d instructions over %0d settings, %0d results compared, %0d mismatches",
			instr_sent, settings_applied, shadow.steps_seen, shadow.mismatches);
		$display("tb: all opcodes, pointer choices 0..7, program lengths 0..65535, gaps and holds");
		if (shadow.mismatches == 0 && shadow.awaited_steps.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
